// ----- src/lzwc_pkg.sv -----
// lzwc_pkg: shared constants and types of the LZW compressor.
// No dependencies; used by lzwc_hash, lzwc_out_fifo and lzw_compressor.

package lzwc_pkg;

   // Default geometry of the phrase dictionary
   localparam int CODE_BITS_DEF     = 12;
   localparam int TABLE_ENTRIES_DEF = 5021;

   // Stream field widths
   localparam int BYTE_W      = 8;
   localparam int CODE_WORD_W = 12;
   localparam int RSP_DATA_W  = 16;

   // Reserved codes
   localparam int EOS_CODE   = 256;
   localparam int FIRST_FREE = 257;

   // Result queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;

   // One result beat
   typedef struct packed {
      logic                   final_code;
      logic [CODE_WORD_W-1:0] code_word;
   } rsp_beat_type;

endpackage

// ----- src/lzwc_ram.sv -----
// lzwc_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.

module lzwc_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 5021
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/lzwc_hash.sv -----
// lzwc_hash: home slot and probe step for a (prefix, byte) pair.
// Depends on lzwc_pkg.

module lzwc_hash #(
   parameter int CODE_BITS     = lzwc_pkg::CODE_BITS_DEF,
   parameter int TABLE_ENTRIES = lzwc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic [CODE_BITS-1:0]             prefix,
   input  logic [lzwc_pkg::BYTE_W-1:0]      data_byte,
   output logic [$clog2(TABLE_ENTRIES)-1:0] home_slot,
   output logic [$clog2(TABLE_ENTRIES)-1:0] probe_step
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   // compare-subtract steps needed to bring a CODE_BITS value below the table size
   localparam int RED_STEPS = ((2 ** CODE_BITS) > TABLE_ENTRIES) ?
                              $clog2(((2 ** CODE_BITS) - 1) / TABLE_ENTRIES + 1) : 0;

   logic [CODE_BITS-1:0] mix;
   logic [CODE_BITS-1:0] rem;
   logic [CODE_BITS:0]   sub;

   // byte shifted up into the top of the code, folded with the prefix
   assign mix = {data_byte, {(CODE_BITS - lzwc_pkg::BYTE_W){1'b0}}} ^ prefix;

   // Reduce modulo the table size by restoring compare-subtract
   always_comb begin
      rem = mix;
      sub = '0;
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         sub = (CODE_BITS + 1)'(TABLE_ENTRIES) << k;
         if ({1'b0, rem} >= sub) begin
            rem = rem - sub[CODE_BITS-1:0];
         end
      end
   end

   assign home_slot = IDX_W'(rem);

   // Step backwards: table size minus home, or 1 at slot zero
   assign probe_step = (home_slot == '0) ? IDX_W'(1) :
                       IDX_W'((IDX_W + 1)'(TABLE_ENTRIES) - {1'b0, home_slot});

endmodule

// ----- src/lzwc_out_fifo.sv -----
// lzwc_out_fifo: small result queue between the dictionary engine and rsp port.
// Depends on lzwc_pkg.

module lzwc_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  lzwc_pkg::rsp_beat_type push_beat,
   output logic                   push_room,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output lzwc_pkg::rsp_beat_type pop_beat
);

   lzwc_pkg::rsp_beat_type           slot_ff [lzwc_pkg::OUT_DEPTH];
   logic [lzwc_pkg::OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lzwc_pkg::OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lzwc_pkg::OUT_PTR_W:0]     count_ff, count_in;
   logic                             pop;

   assign push_room = (count_ff != (lzwc_pkg::OUT_PTR_W + 1)'(lzwc_pkg::OUT_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid & pop_ready;
   assign pop_beat  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/lzw_compressor.sv -----
// lzw_compressor: top level, LZW engine over a hashed phrase dictionary in RAM.
// Depends on lzwc_pkg, lzwc_ram, lzwc_hash, lzwc_out_fifo.
//
//   port group | dir | tdata                     | tlast
//   req_       | in  | [7:0] data_byte           | end_of_input
//   rsp_       | out | [11:0] code_word, 0-fill  | final_code
//
// A byte with an open phrase passes accept (ST_IDLE), hash (ST_HASH) and dictionary
// read (ST_PROBE) when the first slot decides it; each further RAM probe repeats
// the dictionary read. The first byte of a stream only opens the phrase.
// The last byte of a stream then passes ST_FLUSH and ST_EOS to queue the prefix
// and code 256. After reset and after each stream the dictionary RAM is cleared,
// one entry a cycle, while req_tready stays low.
// A full result queue (4 beats) stalls the engine until rsp_tready drains it.

module lzw_compressor #(
   parameter int CODE_BITS     = lzwc_pkg::CODE_BITS_DEF,
   parameter int TABLE_ENTRIES = lzwc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  logic                            req_tlast,  // end_of_input
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lzwc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [11:0] code_word, rest 0
   output logic                            rsp_tlast   // final_code
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int NEXT_W  = CODE_BITS + 1;
   localparam int BYTE_W  = lzwc_pkg::BYTE_W;
   // entry: {byte, prefix, code, used}
   localparam int ENTRY_W = 1 + 2 * CODE_BITS + BYTE_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_FLUSH,
      ST_EOS
   } state_type;

   state_type            state_ff, state_in;
   logic                 have_prefix_ff, have_prefix_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic [NEXT_W-1:0]    free_code_ff, free_code_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;

   logic [IDX_W-1:0]     home_slot;
   logic [IDX_W-1:0]     probe_step;
   logic [IDX_W-1:0]     next_idx;
   logic [IDX_W:0]       wrap_sum;

   logic                 ent_used;
   logic [CODE_BITS-1:0] ent_code;
   logic [CODE_BITS-1:0] ent_prefix;
   logic [BYTE_W-1:0]    ent_byte;
   logic                 ent_match;
   logic                 probes_done;

   logic                   push_valid;
   lzwc_pkg::rsp_beat_type push_beat;
   logic                   push_room;
   lzwc_pkg::rsp_beat_type pop_beat;

   // Dictionary storage
   lzwc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Home slot and step of the pending pair
   lzwc_hash #(
      .CODE_BITS     (CODE_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_hash (
      .prefix     (prefix_ff),
      .data_byte  (byte_ff),
      .home_slot  (home_slot),
      .probe_step (probe_step)
   );

   // Result queue
   lzwc_out_fifo u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_beat  (push_beat),
      .push_room  (push_room),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_beat   (pop_beat)
   );

   assign rsp_tdata  = lzwc_pkg::RSP_DATA_W'(pop_beat.code_word);
   assign rsp_tlast  = pop_beat.final_code;
   assign req_tready = (state_ff == ST_IDLE);

   // Entry read back from the probed slot
   assign ent_used    = ram_rdata[0];
   assign ent_code    = ram_rdata[CODE_BITS:1];
   assign ent_prefix  = ram_rdata[2*CODE_BITS:CODE_BITS+1];
   assign ent_byte    = ram_rdata[2*CODE_BITS+BYTE_W:2*CODE_BITS+1];
   assign ent_match   = ent_used && (ent_prefix == prefix_ff) && (ent_byte == byte_ff);
   assign probes_done = (cnt_ff == IDX_W'(TABLE_ENTRIES - 1));

   // Backward probe with wraparound
   assign wrap_sum = {1'b0, idx_ff} + (IDX_W + 1)'(TABLE_ENTRIES) - {1'b0, step_ff};
   assign next_idx = (idx_ff >= step_ff) ? idx_ff - step_ff : wrap_sum[IDX_W-1:0];

   // Engine control
   always_comb begin
      state_in       = state_ff;
      have_prefix_in = have_prefix_ff;
      prefix_in      = prefix_ff;
      free_code_in   = free_code_ff;
      clr_in         = clr_ff;
      byte_in        = byte_ff;
      last_in        = last_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      cnt_in         = cnt_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = {byte_ff, prefix_ff, free_code_ff[CODE_BITS-1:0], 1'b1};
      ram_raddr      = idx_ff;
      push_valid     = 1'b0;
      push_beat      = '{final_code: 1'b0,
                         code_word:  lzwc_pkg::CODE_WORD_W'(prefix_ff)};
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               last_in = req_tlast;
               if (!have_prefix_ff) begin
                  // first byte opens the phrase
                  prefix_in      = CODE_BITS'(req_tdata);
                  have_prefix_in = 1'b1;
                  state_in       = req_tlast ? ST_FLUSH : ST_IDLE;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            ram_raddr = home_slot;
            idx_in    = home_slot;
            step_in   = probe_step;
            cnt_in    = '0;
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            if (ent_match) begin
               // phrase grows
               prefix_in = ent_code;
               state_in  = last_ff ? ST_FLUSH : ST_IDLE;
            end else if (!ent_used || probes_done) begin
               // miss: add the pair if a slot and a code remain, emit prefix
               if (push_room) begin
                  push_valid = 1'b1;
                  if (!ent_used && !free_code_ff[CODE_BITS]) begin
                     ram_we       = 1'b1;
                     free_code_in = free_code_ff + 1'b1;
                  end
                  prefix_in = CODE_BITS'(byte_ff);
                  state_in  = last_ff ? ST_FLUSH : ST_IDLE;
               end
            end else begin
               idx_in    = next_idx;
               cnt_in    = cnt_ff + 1'b1;
               ram_raddr = next_idx;
            end
         end
         ST_FLUSH: begin
            if (push_room) begin
               push_valid = 1'b1;
               state_in   = ST_EOS;
            end
         end
         ST_EOS: begin
            push_beat = '{final_code: 1'b1,
                          code_word:  lzwc_pkg::CODE_WORD_W'(lzwc_pkg::EOS_CODE)};
            if (push_room) begin
               push_valid     = 1'b1;
               have_prefix_in = 1'b0;
               prefix_in      = '0;
               free_code_in   = NEXT_W'(lzwc_pkg::FIRST_FREE);
               clr_in         = '0;
               state_in       = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         state_ff       <= ST_CLEAR;
         have_prefix_ff <= 1'b0;
         prefix_ff      <= '0;
         free_code_ff   <= NEXT_W'(lzwc_pkg::FIRST_FREE);
         clr_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         have_prefix_ff <= have_prefix_in;
         prefix_ff      <= prefix_in;
         free_code_ff   <= free_code_in;
         clr_ff         <= clr_in;
      end
   end

endmodule
